// ----- rtl/core/drus_pkg.sv -----
package drus_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int CFG_COUNT = 5;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PANEL_WIDTH = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PANEL_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIXEL_BYTES = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FB_BASE = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HAS_VSYNC = 3'd4;

  localparam logic [11:0] PANEL_WIDTH_RST = 12'd320;
  localparam logic [11:0] PANEL_HEIGHT_RST = 12'd480;
  localparam logic [2:0] BPP_RST = 3'd2;

  // event codes
  localparam logic [2:0] FN_UPDATE = 3'd0;
  localparam logic [2:0] FN_VSYNC = 3'd1;
  localparam logic [2:0] FN_DMA_DONE = 3'd2;
  localparam logic [2:0] FN_RESUME = 3'd3;
  localparam logic [2:0] FN_SUSPEND = 3'd4;
  localparam logic [2:0] FN_PANEL_ON = 3'd5;

  // result codes
  localparam logic [3:0] K_NONE = 4'd0;
  localparam logic [3:0] K_DMA_START = 4'd1;
  localparam logic [3:0] K_INVALID = 4'd2;
  localparam logic [3:0] K_QUEUED_VSYNC = 4'd3;
  localparam logic [3:0] K_QUEUED_TIMER = 4'd4;
  localparam logic [3:0] K_POWER_ON = 4'd5;
  localparam logic [3:0] K_ASLEEP = 4'd6;
  localparam logic [3:0] K_BUSY = 4'd7;
  localparam logic [3:0] K_REFUSED = 4'd8;

  typedef enum logic [2:0] {
    PS_AWAKE    = 3'd0,
    PS_WAKING   = 3'd1,
    PS_UPDATING = 3'd3,
    PS_SLEEPING = 3'd4
  } power_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right_excl;
    logic [15:0] bottom_excl;
    logic [12:0] y_offset;
    logic        pan_req;
    logic        panel_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] dma_addr;
    logic [13:0] dma_stride;
    logic [11:0] win_width;
    logic [11:0] win_height;
    logic [15:0] win_x;
    logic [15:0] win_y;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic dma_go;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/drus_ctrl.sv -----
module drus_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  drus_pkg::sts_t sts,
  output drus_pkg::cmd_t cmd
);
  import drus_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.dma_go ? ST_MUL : ST_FINISH;
      end
      ST_MUL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_FINISH: begin
        cmd.load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/drus_dp.sv -----
module drus_dp #(
  parameter int COUNT_WIDTH = drus_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = drus_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  drus_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [drus_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [drus_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  drus_pkg::cmd_t                      cmd,
  output drus_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output drus_pkg::out_item_t                 out_data
);
  import drus_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int RW = (CW > 13) ? CW : 13; // holds panel size plus one

  // configuration
  logic [11:0] panel_width;
  logic [11:0] panel_height;
  logic [2:0]  pixel_bytes;
  logic [31:0] fb_base;
  logic        has_vsync;

  // scheduler state
  power_t                 power_state, power_state_next;
  logic [COUNT_WIDTH-1:0] frames_requested, frames_requested_next;
  logic [COUNT_WIDTH-1:0] frames_done, frames_done_next;
  logic [COUNT_WIDTH-1:0] full_update_frame, full_update_frame_next;
  logic [CW-1:0]          rect_left, rect_left_next;
  logic [CW-1:0]          rect_top, rect_top_next;
  logic [CW-1:0]          rect_right, rect_right_next;
  logic [CW-1:0]          rect_bottom, rect_bottom_next;
  logic [12:0]            pan_offset, pan_offset_next;

  // work registers
  in_item_t    itm;
  logic [3:0]  kind, kind_next;
  logic [28:0] row_prod;
  logic [31:0] scaled;
  logic [13:0] stride;
  logic [CW-1:0] win_x_r, win_y_r, win_w_r, win_h_r;

  logic [CW-1:0] l, t, r, b;
  logic [CW-1:0] w, h, pw_c, ph_c;
  logic          bad, full_pan;
  logic [RW-1:0] left_rst, top_rst;
  logic [16:0]   row;
  logic [29:0]   lin;
  logic [14:0]   stride_full;
  logic [32:0]   scaled_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
      pixel_bytes <= BPP_RST;
      fb_base <= '0;
      has_vsync <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_WIDTH: panel_width <= cfg_data[11:0];
        CFG_PANEL_HEIGHT: panel_height <= cfg_data[11:0];
        CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[2:0];
        CFG_FB_BASE: fb_base <= cfg_data;
        CFG_HAS_VSYNC: has_vsync <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign l = itm.left[CW-1:0];
  assign t = itm.top[CW-1:0];
  assign r = itm.right_excl[CW-1:0];
  assign b = itm.bottom_excl[CW-1:0];
  assign pw_c = CW'(panel_width);
  assign ph_c = CW'(panel_height);

  assign bad = (rect_right < rect_left) || (rect_bottom < rect_top);
  assign w = bad ? '0 : rect_right - rect_left;
  assign h = bad ? '0 : rect_bottom - rect_top;
  assign left_rst = RW'(panel_width) + RW'(1);
  assign top_rst = RW'(panel_height) + RW'(1);
  assign full_pan = (l == '0) && (t == '0) && (r == pw_c) && (b == ph_c);

  always_comb begin
    power_state_next = power_state;
    frames_requested_next = frames_requested;
    frames_done_next = frames_done;
    full_update_frame_next = full_update_frame;
    rect_left_next = rect_left;
    rect_top_next = rect_top;
    rect_right_next = rect_right;
    rect_bottom_next = rect_bottom;
    pan_offset_next = pan_offset;
    kind_next = K_NONE;
    case (itm.func)
      FN_UPDATE: begin
        if (power_state == PS_SLEEPING) begin
          kind_next = K_ASLEEP;
        end else if ((itm.pan_req && frames_requested != frames_done) ||
                     power_state == PS_UPDATING) begin
          kind_next = K_BUSY;
        end else begin
          frames_requested_next = frames_requested + COUNT_WIDTH'(1);
          if (itm.pan_req) begin
            pan_offset_next = itm.y_offset;
            if (full_pan && power_state == PS_WAKING) begin
              full_update_frame_next = frames_requested + COUNT_WIDTH'(1);
              power_state_next = PS_UPDATING;
            end
          end
          if (l < rect_left) rect_left_next = l;
          if (t < rect_top) rect_top_next = t;
          if (r > rect_right) rect_right_next = r;
          if (b > rect_bottom) rect_bottom_next = b;
          kind_next = (has_vsync && power_state == PS_AWAKE) ?
                      K_QUEUED_VSYNC : K_QUEUED_TIMER;
        end
      end
      FN_VSYNC: begin
        if (frames_done == frames_requested) begin
          kind_next = K_NONE;
        end else if (power_state == PS_SLEEPING) begin
          kind_next = K_ASLEEP;
        end else begin
          rect_left_next = left_rst[CW-1:0];
          rect_top_next = top_rst[CW-1:0];
          rect_right_next = '0;
          rect_bottom_next = '0;
          if (bad || w > pw_c || h > ph_c || w == '0 || h == '0) begin
            frames_done_next = frames_requested;
            kind_next = K_INVALID;
          end else begin
            kind_next = K_DMA_START;
          end
        end
      end
      FN_DMA_DONE: begin
        frames_done_next = frames_requested;
        if (power_state == PS_UPDATING && frames_requested == full_update_frame)
          kind_next = K_POWER_ON;
      end
      FN_RESUME: begin
        if (!itm.panel_ok) begin
          kind_next = K_REFUSED;
        end else begin
          frames_requested_next = '0;
          frames_done_next = '0;
          full_update_frame_next = '0;
          power_state_next = PS_WAKING;
        end
      end
      FN_SUSPEND: begin
        power_state_next = PS_SLEEPING;
      end
      FN_PANEL_ON: begin
        if (power_state == PS_UPDATING) begin
          if (itm.panel_ok) power_state_next = PS_AWAKE;
          else kind_next = K_REFUSED;
        end
      end
      default: begin
        kind_next = K_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_state <= PS_WAKING;
      frames_requested <= '0;
      frames_done <= '0;
      full_update_frame <= '0;
      rect_left <= '0;
      rect_top <= '0;
      rect_right <= '0;
      rect_bottom <= '0;
      pan_offset <= '0;
    end else if (cmd.exec) begin
      power_state <= power_state_next;
      frames_requested <= frames_requested_next;
      frames_done <= frames_done_next;
      full_update_frame <= full_update_frame_next;
      rect_left <= rect_left_next;
      rect_top <= rect_top_next;
      rect_right <= rect_right_next;
      rect_bottom <= rect_bottom_next;
      pan_offset <= pan_offset_next;
    end
  end

  // address: row product, then column and pixel size, then base
  assign row = 17'(pan_offset) + 17'(rect_top);
  assign stride_full = 15'(panel_width) * 15'(pixel_bytes);
  assign lin = 30'(row_prod) + 30'(win_x_r);
  assign scaled_full = 33'(lin) * 33'(pixel_bytes);

  always_ff @(posedge clk) begin
    if (cmd.capture) itm <= in_data;
    if (cmd.exec) begin
      kind <= kind_next;
      row_prod <= 29'(panel_width) * 29'(row);
      stride <= stride_full[13:0];
      win_x_r <= rect_left;
      win_y_r <= rect_top;
      win_w_r <= w;
      win_h_r <= h;
    end
    if (cmd.mul) scaled <= scaled_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.kind <= kind;
      if (kind == K_DMA_START) begin
        out_data.dma_addr <= scaled + fb_base;
        out_data.dma_stride <= stride;
        out_data.win_width <= win_w_r[11:0];
        out_data.win_height <= win_h_r[11:0];
        out_data.win_x <= 16'(win_x_r);
        out_data.win_y <= 16'(win_y_r);
      end else begin
        out_data.dma_addr <= '0;
        out_data.dma_stride <= '0;
        out_data.win_width <= '0;
        out_data.win_height <= '0;
        out_data.win_x <= '0;
        out_data.win_y <= '0;
      end
    end
  end

  assign sts.dma_go = (kind_next == K_DMA_START);
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ----- rtl/core/dirty_rect_display_update_scheduler_core.sv -----
// display refresh scheduler, one event in, one result out
// input channel in_valid/in_ready/in_data carries one event per transaction:
// update request, vsync or timer tick, dma done, resume, suspend, panel on.
// output channel out_valid/out_ready/out_data returns exactly one result per
// event; for a dma start it carries the source address, stride and window.
// configuration: cfg_we with cfg_index/cfg_data writes panel size, pixel size,
// framebuffer base and vsync presence; write only while no event is in flight.
// steps: a dma start passes decode and row multiply, column add and pixel-size
// multiply, then base add before out_valid; every other event skips the
// multiply step. one event is worked on at a time: a new event is accepted
// only after the last one's result is loaded into the output register.
// the output register lets the next event be accepted while a result waits.
// when the receiver stalls, the finished result holds and the following one
// waits in the scheduler until the output register frees.
// reset: power state waking, counters and dirty rectangle cleared, registers
// back to 320x480, 2 bytes per pixel, base 0, vsync present.
module dirty_rect_display_update_scheduler_core #(
  parameter int COUNT_WIDTH = drus_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = drus_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  drus_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output drus_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [drus_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [drus_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import drus_pkg::*;

  cmd_t cmd;
  sts_t sts;

  drus_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  drus_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
